FILE: rtl/core/circle_brush_grid_painter_assert.svh
// assertion macros for the circle brush grid painter
`ifndef CIRCLE_BRUSH_GRID_PAINTER_ASSERT_SVH
`define CIRCLE_BRUSH_GRID_PAINTER_ASSERT_SVH
`ifndef ASSERT_OFF
`define CBGP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define CBGP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define CBGP_ASSERT(lbl, prop, msg)
`define CBGP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/core/cbgp_pkg.sv
// shared constants and types of the circle brush grid painter
`default_nettype none
package cbgp_pkg;
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int MAX_RADIUS = 63;

   localparam int CELLS   = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int XIDX_W  = $clog2(MAX_WIDTH);
   localparam int KIND_W  = 7;
   localparam int DIM_W   = 9;
   localparam int COORD_W = 11;
   localparam int BOX_W   = 12;
   localparam int COUNT_W = 17;
   localparam int RAD_W   = 6;
   localparam int OFS_W   = RAD_W + 1;
   localparam int SQ_W    = 2 * RAD_W;
   localparam int MUL_W   = 9;
   localparam int PROD_W  = 2 * MUL_W;

   localparam logic REG_GRID_WIDTH  = 1'b0;
   localparam logic REG_GRID_HEIGHT = 1'b1;

   typedef struct packed {
      logic [MUL_W-1:0] op_a;
      logic [MUL_W-1:0] op_b;
   } mul_req_type;
endpackage
`default_nettype wire

FILE: rtl/core/cbgp_ram.sv
// generic single write, single read ram with registered read data
`default_nettype none
module cbgp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

FILE: rtl/core/cbgp_mul.sv
// shared unsigned multiplier with registered product
`default_nettype none
module cbgp_mul (
   input  wire logic                       clock,
   input  wire cbgp_pkg::mul_req_type      req,
   output logic [cbgp_pkg::PROD_W-1:0]     prod
);
   logic [cbgp_pkg::PROD_W-1:0] prod_ff;
   logic [cbgp_pkg::PROD_W-1:0] prod_in;

   assign prod_in = req.op_a * req.op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;
endmodule
`default_nettype wire

FILE: rtl/core/circle_brush_grid_painter.sv
// circle brush grid painter top level: sequencer, cell store and counters
//
// channel  dir  handshake              payload
// req      in   req_valid/req_ready    center_x, center_y, brush_radius, brush_kind
// rsp      out  rsp_valid/rsp_ready    filled_count, dirty box (min/max x, y)
// csr      in   csr_we                 csr_index, csr_wdata
//
// after reset the cell store is swept to empty with req_ready low
// each point goes through the shared multiplier, each new column also squares dx
// first, and each on-grid point inside the circle adds a read and a write of its cell
// an item is not through until its result has entered the output register, so
// the next accept comes later while the previous result still waits
// req_ready is high only between items; one finished result may wait in the
// output register while the next item is worked on
`default_nettype none
`include "circle_brush_grid_painter_assert.svh"
module circle_brush_grid_painter (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [cbgp_pkg::COORD_W-1:0]  req_center_x,
   input  wire logic signed [cbgp_pkg::COORD_W-1:0]  req_center_y,
   input  wire logic        [cbgp_pkg::RAD_W-1:0]    req_brush_radius,
   input  wire logic        [cbgp_pkg::KIND_W-1:0]   req_brush_kind,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic             [cbgp_pkg::COUNT_W-1:0]  rsp_filled_count,
   output logic signed      [cbgp_pkg::BOX_W-1:0]    rsp_dirty_min_x,
   output logic signed      [cbgp_pkg::BOX_W-1:0]    rsp_dirty_max_x,
   output logic signed      [cbgp_pkg::BOX_W-1:0]    rsp_dirty_min_y,
   output logic signed      [cbgp_pkg::BOX_W-1:0]    rsp_dirty_max_y,
   input  wire logic                                 csr_we,
   input  wire logic                                 csr_index,
   input  wire logic        [cbgp_pkg::DIM_W-1:0]    csr_wdata
);
   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_RSQ   = 4'd2;
   localparam logic [3:0] S_RCAP  = 4'd3;
   localparam logic [3:0] S_DXSQ  = 4'd4;
   localparam logic [3:0] S_DXCAP = 4'd5;
   localparam logic [3:0] S_DYSQ  = 4'd6;
   localparam logic [3:0] S_TEST  = 4'd7;
   localparam logic [3:0] S_ADDR  = 4'd8;
   localparam logic [3:0] S_WRITE = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   function automatic logic [cbgp_pkg::RAD_W-1:0] abs_ofs(
      input logic signed [cbgp_pkg::OFS_W-1:0] v);
      logic signed [cbgp_pkg::OFS_W-1:0] n;
      n = -v;
      abs_ofs = v[cbgp_pkg::OFS_W-1] ? n[cbgp_pkg::RAD_W-1:0] : v[cbgp_pkg::RAD_W-1:0];
   endfunction

   logic [3:0] state_ff, state_in;
   logic [cbgp_pkg::ADDR_W-1:0] clr_ff, clr_in;
   logic [cbgp_pkg::DIM_W-1:0] grid_width_ff, grid_width_in;
   logic [cbgp_pkg::DIM_W-1:0] grid_height_ff, grid_height_in;
   logic signed [cbgp_pkg::COORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [cbgp_pkg::RAD_W-1:0] rad_ff, rad_in;
   logic [cbgp_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [cbgp_pkg::DIM_W-1:0] w_ff, w_in, h_ff, h_in;
   logic signed [cbgp_pkg::OFS_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [cbgp_pkg::SQ_W-1:0] rsq_ff, rsq_in, dxsq_ff, dxsq_in;
   logic [cbgp_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic [cbgp_pkg::COUNT_W-1:0] count_ff, count_in;
   logic signed [cbgp_pkg::BOX_W-1:0] bmin_x_ff, bmin_x_in, bmax_x_ff, bmax_x_in;
   logic signed [cbgp_pkg::BOX_W-1:0] bmin_y_ff, bmin_y_in, bmax_y_ff, bmax_y_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [cbgp_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic signed [cbgp_pkg::BOX_W-1:0] rsp_min_x_ff, rsp_min_x_in, rsp_max_x_ff, rsp_max_x_in;
   logic signed [cbgp_pkg::BOX_W-1:0] rsp_min_y_ff, rsp_min_y_in, rsp_max_y_ff, rsp_max_y_in;

   cbgp_pkg::mul_req_type mul_req;
   logic [cbgp_pkg::PROD_W-1:0] prod;
   logic ram_we;
   logic [cbgp_pkg::ADDR_W-1:0] ram_waddr;
   logic [cbgp_pkg::KIND_W-1:0] ram_wdata, ram_rdata;

   logic signed [cbgp_pkg::OFS_W-1:0] req_neg_rad, neg_rad;
   logic signed [cbgp_pkg::BOX_W-1:0] pos_x, pos_y, xm, xp, ym, yp;
   logic [cbgp_pkg::SQ_W:0] dist_sq;
   logic in_circle, in_grid, last_dx, last_dy, do_write;
   logic [cbgp_pkg::ADDR_W-1:0] cell_addr;

   assign req_neg_rad = -$signed({1'b0, req_brush_radius});
   assign neg_rad     = -$signed({1'b0, rad_ff});
   assign pos_x = cbgp_pkg::BOX_W'(cx_ff) + cbgp_pkg::BOX_W'(dx_ff);
   assign pos_y = cbgp_pkg::BOX_W'(cy_ff) + cbgp_pkg::BOX_W'(dy_ff);
   assign xm = pos_x - cbgp_pkg::BOX_W'(1);
   assign xp = pos_x + cbgp_pkg::BOX_W'(1);
   assign ym = pos_y - cbgp_pkg::BOX_W'(1);
   assign yp = pos_y + cbgp_pkg::BOX_W'(1);
   assign dist_sq = {1'b0, dxsq_ff} + {1'b0, prod[cbgp_pkg::SQ_W-1:0]};
   assign in_circle = dist_sq <= {1'b0, rsq_ff};
   assign in_grid = !pos_x[cbgp_pkg::BOX_W-1] && !pos_y[cbgp_pkg::BOX_W-1]
                 && (pos_x < $signed(cbgp_pkg::BOX_W'(w_ff)))
                 && (pos_y < $signed(cbgp_pkg::BOX_W'(h_ff)));
   assign last_dx = dx_ff == $signed({1'b0, rad_ff});
   assign last_dy = dy_ff == $signed({1'b0, rad_ff});
   assign cell_addr = prod[cbgp_pkg::ADDR_W-1:0]
                    + {{(cbgp_pkg::ADDR_W-cbgp_pkg::XIDX_W){1'b0}},
                       pos_x[cbgp_pkg::XIDX_W-1:0]};
   assign do_write = (ram_rdata == '0) || (kind_ff == '0);

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      cx_in          = cx_ff;
      cy_in          = cy_ff;
      rad_in         = rad_ff;
      kind_in        = kind_ff;
      w_in           = w_ff;
      h_in           = h_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      rsq_in         = rsq_ff;
      dxsq_in        = dxsq_ff;
      addr_in        = addr_ff;
      count_in       = count_ff;
      bmin_x_in      = bmin_x_ff;
      bmax_x_in      = bmax_x_ff;
      bmin_y_in      = bmin_y_ff;
      bmax_y_in      = bmax_y_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_count_in   = rsp_count_ff;
      rsp_min_x_in   = rsp_min_x_ff;
      rsp_max_x_in   = rsp_max_x_ff;
      rsp_min_y_in   = rsp_min_y_ff;
      rsp_max_y_in   = rsp_max_y_ff;
      mul_req        = '0;
      ram_we         = 1'b0;
      ram_waddr      = addr_ff;
      ram_wdata      = kind_ff;

      if (csr_we) begin
         if (csr_index == cbgp_pkg::REG_GRID_WIDTH) begin
            grid_width_in = csr_wdata;
         end else begin
            grid_height_in = csr_wdata;
         end
      end

      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + cbgp_pkg::ADDR_W'(1);
            if (clr_ff == cbgp_pkg::ADDR_W'(cbgp_pkg::CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cx_in   = req_center_x;
               cy_in   = req_center_y;
               rad_in  = req_brush_radius;
               kind_in = req_brush_kind;
               w_in    = (grid_width_ff > cbgp_pkg::DIM_W'(cbgp_pkg::MAX_WIDTH))
                       ? cbgp_pkg::DIM_W'(cbgp_pkg::MAX_WIDTH) : grid_width_ff;
               h_in    = (grid_height_ff > cbgp_pkg::DIM_W'(cbgp_pkg::MAX_HEIGHT))
                       ? cbgp_pkg::DIM_W'(cbgp_pkg::MAX_HEIGHT) : grid_height_ff;
               dx_in   = req_neg_rad;
               dy_in   = req_neg_rad;
               state_in = S_RSQ;
            end
         end
         S_RSQ: begin
            mul_req.op_a = cbgp_pkg::MUL_W'(rad_ff);
            mul_req.op_b = cbgp_pkg::MUL_W'(rad_ff);
            state_in = S_RCAP;
         end
         S_RCAP: begin
            rsq_in = prod[cbgp_pkg::SQ_W-1:0];
            mul_req.op_a = cbgp_pkg::MUL_W'(abs_ofs(dx_ff));
            mul_req.op_b = cbgp_pkg::MUL_W'(abs_ofs(dx_ff));
            state_in = S_DXCAP;
         end
         S_DXSQ: begin
            mul_req.op_a = cbgp_pkg::MUL_W'(abs_ofs(dx_ff));
            mul_req.op_b = cbgp_pkg::MUL_W'(abs_ofs(dx_ff));
            state_in = S_DXCAP;
         end
         S_DXCAP: begin
            dxsq_in = prod[cbgp_pkg::SQ_W-1:0];
            mul_req.op_a = cbgp_pkg::MUL_W'(abs_ofs(dy_ff));
            mul_req.op_b = cbgp_pkg::MUL_W'(abs_ofs(dy_ff));
            state_in = S_TEST;
         end
         S_DYSQ: begin
            mul_req.op_a = cbgp_pkg::MUL_W'(abs_ofs(dy_ff));
            mul_req.op_b = cbgp_pkg::MUL_W'(abs_ofs(dy_ff));
            state_in = S_TEST;
         end
         S_TEST: begin
            // row base address y*w for the point under test
            mul_req.op_a = pos_y[cbgp_pkg::MUL_W-1:0];
            mul_req.op_b = w_ff;
            if (in_circle && in_grid) begin
               state_in = S_ADDR;
            end else if (!last_dy) begin
               dy_in    = dy_ff + cbgp_pkg::OFS_W'(1);
               state_in = S_DYSQ;
            end else if (!last_dx) begin
               dx_in    = dx_ff + cbgp_pkg::OFS_W'(1);
               dy_in    = neg_rad;
               state_in = S_DXSQ;
            end else begin
               state_in = S_DONE;
            end
         end
         S_ADDR: begin
            addr_in  = cell_addr;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            if (do_write) begin
               ram_we = 1'b1;
               if (ram_rdata != '0 && kind_ff == '0 && count_ff != '0) begin
                  count_in = count_ff - cbgp_pkg::COUNT_W'(1);
               end else if (ram_rdata == '0 && kind_ff != '0) begin
                  count_in = count_ff + cbgp_pkg::COUNT_W'(1);
               end
               bmin_x_in = (xm < bmin_x_ff) ? xm : bmin_x_ff;
               bmax_x_in = (xp > bmax_x_ff) ? xp : bmax_x_ff;
               bmin_y_in = (ym < bmin_y_ff) ? ym : bmin_y_ff;
               bmax_y_in = (yp > bmax_y_ff) ? yp : bmax_y_ff;
            end
            if (!last_dy) begin
               dy_in    = dy_ff + cbgp_pkg::OFS_W'(1);
               state_in = S_DYSQ;
            end else if (!last_dx) begin
               dx_in    = dx_ff + cbgp_pkg::OFS_W'(1);
               dy_in    = neg_rad;
               state_in = S_DXSQ;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
               rsp_min_x_in = bmin_x_ff;
               rsp_max_x_in = bmax_x_ff;
               rsp_min_y_in = bmin_y_ff;
               rsp_max_y_in = bmax_y_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_ff         <= '0;
         grid_width_ff  <= cbgp_pkg::DIM_W'(cbgp_pkg::MAX_WIDTH);
         grid_height_ff <= cbgp_pkg::DIM_W'(cbgp_pkg::MAX_HEIGHT);
         count_ff       <= '0;
         bmin_x_ff      <= '0;
         bmax_x_ff      <= '0;
         bmin_y_ff      <= '0;
         bmax_y_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         count_ff       <= count_in;
         bmin_x_ff      <= bmin_x_in;
         bmax_x_ff      <= bmax_x_in;
         bmin_y_ff      <= bmin_y_in;
         bmax_y_ff      <= bmax_y_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      rad_ff       <= rad_in;
      kind_ff      <= kind_in;
      w_ff         <= w_in;
      h_ff         <= h_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      rsq_ff       <= rsq_in;
      dxsq_ff      <= dxsq_in;
      addr_ff      <= addr_in;
      rsp_count_ff <= rsp_count_in;
      rsp_min_x_ff <= rsp_min_x_in;
      rsp_max_x_ff <= rsp_max_x_in;
      rsp_min_y_ff <= rsp_min_y_in;
      rsp_max_y_ff <= rsp_max_y_in;
   end

   cbgp_mul u_mul (
      .clock (clock),
      .req   (mul_req),
      .prod  (prod)
   );

   cbgp_ram #(
      .WIDTH (cbgp_pkg::KIND_W),
      .DEPTH (cbgp_pkg::CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (cell_addr),
      .rd_data (ram_rdata)
   );

   assign req_ready        = state_ff == S_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_filled_count = rsp_count_ff;
   assign rsp_dirty_min_x  = rsp_min_x_ff;
   assign rsp_dirty_max_x  = rsp_max_x_ff;
   assign rsp_dirty_min_y  = rsp_min_y_ff;
   assign rsp_dirty_max_y  = rsp_max_y_ff;

   `CBGP_ASSERT(a_count_range, count_ff <= cbgp_pkg::COUNT_W'(cbgp_pkg::CELLS), "count above cells")
   `CBGP_ASSERT_NEXT(a_count_hold, state_ff != S_WRITE, $stable(count_ff), "count moved off write")
   `CBGP_ASSERT(a_box_order, (bmin_x_ff <= bmax_x_ff) && (bmin_y_ff <= bmax_y_ff), "box inverted")
   `CBGP_ASSERT(a_rsp_src, $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE), "stray result")
endmodule
`default_nettype wire

FILE: bench/testbench.sv
// testbench for the circle brush grid painter: grid shadow scoreboard, drivers and test sequence
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [cbgp_pkg::COORD_W-1:0] center_x;
      logic signed [cbgp_pkg::COORD_W-1:0] center_y;
      logic        [cbgp_pkg::RAD_W-1:0]   radius;
      logic        [cbgp_pkg::KIND_W-1:0]  kind;
   } paint_req_type;

   typedef struct packed {
      logic        [cbgp_pkg::COUNT_W-1:0] filled_count;
      logic signed [cbgp_pkg::BOX_W-1:0]   min_x;
      logic signed [cbgp_pkg::BOX_W-1:0]   max_x;
      logic signed [cbgp_pkg::BOX_W-1:0]   min_y;
      logic signed [cbgp_pkg::BOX_W-1:0]   max_y;
   } paint_summary_type;

   class grid_shadow_type;
      bit [cbgp_pkg::KIND_W-1:0] cells [cbgp_pkg::CELLS];
      int                        occupied;
      int                        lo_x, hi_x, lo_y, hi_y;
      int                        width_reg, height_reg;
      int                        errors;
      paint_summary_type         pending_summaries [$];

      function new();
         occupied = 0;
         lo_x = 0;
         hi_x = 0;
         lo_y = 0;
         hi_y = 0;
         width_reg = 256;
         height_reg = 256;
         errors = 0;
      endfunction

      function void write_reg(logic idx, int value);
         if (idx == cbgp_pkg::REG_GRID_WIDTH) width_reg = value;
         else height_reg = value;
      endfunction

      function void note_request(paint_req_type rq);
         int cx, cy, rad, w, h, dx, dy, x, y, idx;
         bit [cbgp_pkg::KIND_W-1:0] prior;
         paint_summary_type s;
         cx = $signed(rq.center_x);
         cy = $signed(rq.center_y);
         rad = rq.radius;
         if (rad > cbgp_pkg::MAX_RADIUS) rad = cbgp_pkg::MAX_RADIUS;
         w = (width_reg > cbgp_pkg::MAX_WIDTH) ? cbgp_pkg::MAX_WIDTH : width_reg;
         h = (height_reg > cbgp_pkg::MAX_HEIGHT) ? cbgp_pkg::MAX_HEIGHT : height_reg;
         for (dx = -rad; dx <= rad; dx++) begin
            for (dy = -rad; dy <= rad; dy++) begin
               x = cx + dx;
               y = cy + dy;
               if (dx * dx + dy * dy <= rad * rad && x >= 0 && x < w && y >= 0 && y < h) begin
                  idx = y * w + x;
                  prior = cells[idx];
                  if (prior == 0 || rq.kind == 0) begin
                     if (prior != 0 && rq.kind == 0 && occupied > 0) occupied--;
                     if (prior == 0 && rq.kind != 0) occupied++;
                     cells[idx] = rq.kind;
                     if (x - 1 < lo_x) lo_x = x - 1;
                     if (x + 1 > hi_x) hi_x = x + 1;
                     if (y - 1 < lo_y) lo_y = y - 1;
                     if (y + 1 > hi_y) hi_y = y + 1;
                  end
               end
            end
         end
         s.filled_count = cbgp_pkg::COUNT_W'(occupied);
         s.min_x = cbgp_pkg::BOX_W'(lo_x);
         s.max_x = cbgp_pkg::BOX_W'(hi_x);
         s.min_y = cbgp_pkg::BOX_W'(lo_y);
         s.max_y = cbgp_pkg::BOX_W'(hi_y);
         pending_summaries.push_back(s);
      endfunction

      function void check_summary(paint_summary_type got);
         paint_summary_type want;
         if (pending_summaries.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected summary: count %0d box x %0d..%0d y %0d..%0d",
                        got.filled_count, got.min_x, got.max_x, got.min_y, got.max_y);
            return;
         end
         want = pending_summaries.pop_front();
         if (got.filled_count != want.filled_count || got.min_x != want.min_x ||
             got.max_x != want.max_x || got.min_y != want.min_y || got.max_y != want.max_y) begin
            errors++;
            if (errors <= 10)
               $display({"summary mismatch: exp count %0d box x %0d..%0d y %0d..%0d,",
                         " got count %0d box x %0d..%0d y %0d..%0d"},
                        want.filled_count, want.min_x, want.max_x, want.min_y, want.max_y,
                        got.filled_count, got.min_x, got.max_x, got.min_y, got.max_y);
         end
      endfunction
   endclass

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic signed [cbgp_pkg::COORD_W-1:0]  req_center_x = '0;
   logic signed [cbgp_pkg::COORD_W-1:0]  req_center_y = '0;
   logic        [cbgp_pkg::RAD_W-1:0]    req_brush_radius = '0;
   logic        [cbgp_pkg::KIND_W-1:0]   req_brush_kind = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic        [cbgp_pkg::COUNT_W-1:0]  rsp_filled_count;
   logic signed [cbgp_pkg::BOX_W-1:0]    rsp_dirty_min_x;
   logic signed [cbgp_pkg::BOX_W-1:0]    rsp_dirty_max_x;
   logic signed [cbgp_pkg::BOX_W-1:0]    rsp_dirty_min_y;
   logic signed [cbgp_pkg::BOX_W-1:0]    rsp_dirty_max_y;
   logic                                 csr_we = 1'b0;
   logic                                 csr_index = cbgp_pkg::REG_GRID_WIDTH;
   logic        [cbgp_pkg::DIM_W-1:0]    csr_wdata = '0;

   grid_shadow_type            shadow = new();
   int                         req_idle_pct = 37;
   int                         rsp_idle_pct = 73;
   longint                     cycle_count = 0;
   // cleanup sweep after reset plus slack; each item adds its own share
   longint                     cycle_budget = 3 * 65536 + 100000;

   circle_brush_grid_painter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_brush_radius (req_brush_radius),
      .req_brush_kind   (req_brush_kind),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_filled_count (rsp_filled_count),
      .rsp_dirty_min_x  (rsp_dirty_min_x),
      .rsp_dirty_max_x  (rsp_dirty_max_x),
      .rsp_dirty_min_y  (rsp_dirty_min_y),
      .rsp_dirty_max_y  (rsp_dirty_max_y),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         shadow.check_summary('{filled_count: rsp_filled_count,
                                min_x: rsp_dirty_min_x, max_x: rsp_dirty_max_x,
                                min_y: rsp_dirty_min_y, max_y: rsp_dirty_max_y});
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > cycle_budget) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   task automatic paint(input int cx, input int cy, input int rad, input int kind);
      paint_req_type rq;
      int span;
      rq.center_x = cbgp_pkg::COORD_W'(cx);
      rq.center_y = cbgp_pkg::COORD_W'(cy);
      rq.radius = cbgp_pkg::RAD_W'(rad);
      rq.kind = cbgp_pkg::KIND_W'(kind);
      span = 2 * rad + 1;
      cycle_budget += 3 * (4 * span * span + 2 * span + 16) + 600;
      while ($urandom_range(99) < req_idle_pct) @(negedge clock);
      req_valid = 1'b1;
      req_center_x = rq.center_x;
      req_center_y = rq.center_y;
      req_brush_radius = rq.radius;
      req_brush_kind = rq.kind;
      do @(posedge clock); while (!req_ready);
      shadow.note_request(rq);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic write_reg(input logic idx, input int value);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = cbgp_pkg::DIM_W'(value);
      shadow.write_reg(idx, value);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // wait until every summary is back and the block takes items again
   task automatic settle();
      while (shadow.pending_summaries.size() != 0 || !req_ready) @(negedge clock);
   endtask

   task automatic paint_random(input int count);
      int w_eff, h_eff, cx, cy, rad, kind, pick, last_kind;
      last_kind = 1;
      w_eff = (shadow.width_reg > cbgp_pkg::MAX_WIDTH) ? cbgp_pkg::MAX_WIDTH
                                                        : shadow.width_reg;
      h_eff = (shadow.height_reg > cbgp_pkg::MAX_HEIGHT) ? cbgp_pkg::MAX_HEIGHT
                                                          : shadow.height_reg;
      repeat (count) begin
         if ($urandom_range(9) == 0) begin
            cx = int'($urandom_range(2047)) - 1024;
            cy = int'($urandom_range(2047)) - 1024;
         end else begin
            cx = int'($urandom_range(w_eff + 15)) - 8;
            cy = int'($urandom_range(h_eff + 15)) - 8;
         end
         pick = $urandom_range(999);
         if (pick < 600) rad = $urandom_range(3);
         else if (pick < 900) rad = $urandom_range(10, 4);
         else if (pick < 995) rad = $urandom_range(24, 11);
         else rad = $urandom_range(63, 25);
         pick = $urandom_range(9);
         if (pick < 3) kind = 0;
         else if (pick == 3) kind = last_kind;
         else kind = $urandom_range(127, 1);
         last_kind = kind;
         paint(cx, cy, rad, kind);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      settle();

      // reset geometry: corners, off-grid, overpaint, erase, edges
      paint(0, 0, 0, 1);
      paint(255, 255, 0, 127);
      paint(-1024, -1024, 63, 5);
      paint(1023, 1023, 63, 3);
      paint(128, 128, 63, 42);
      paint(128, 128, 10, 99);
      paint(128, 128, 5, 0);
      paint(128, 128, 5, 0);
      paint(128, 128, 4, 77);
      paint(-3, 5, 4, 9);
      paint(260, 100, 6, 9);
      paint(10, -2, 3, 85);
      paint(10, 258, 3, 42);
      paint(0, 0, 32, 127);

      // empty grid in one dimension
      settle();
      write_reg(cbgp_pkg::REG_GRID_WIDTH, 0);
      paint(0, 0, 5, 1);
      settle();
      write_reg(cbgp_pkg::REG_GRID_WIDTH, 256);
      write_reg(cbgp_pkg::REG_GRID_HEIGHT, 0);
      paint(10, 10, 5, 2);

      // oversized registers saturate
      settle();
      write_reg(cbgp_pkg::REG_GRID_WIDTH, 511);
      write_reg(cbgp_pkg::REG_GRID_HEIGHT, 511);
      paint(250, 250, 8, 7);
      paint(0, 0, 2, 64);

      // single cell grid
      settle();
      write_reg(cbgp_pkg::REG_GRID_WIDTH, 1);
      write_reg(cbgp_pkg::REG_GRID_HEIGHT, 1);
      paint(0, 0, 0, 1);
      paint(0, 0, 3, 0);
      paint(0, 0, 2, 17);

      settle();
      write_reg(cbgp_pkg::REG_GRID_WIDTH, 37);
      write_reg(cbgp_pkg::REG_GRID_HEIGHT, 23);
      paint_random(450);

      settle();
      req_idle_pct = 73;
      rsp_idle_pct = 37;
      write_reg(cbgp_pkg::REG_GRID_WIDTH, 200);
      write_reg(cbgp_pkg::REG_GRID_HEIGHT, 64);
      paint_random(450);

      settle();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      write_reg(cbgp_pkg::REG_GRID_WIDTH, 100);
      write_reg(cbgp_pkg::REG_GRID_HEIGHT, 9);
      paint_random(450);

      settle();
      repeat (64) @(negedge clock);
      if (shadow.errors == 0 && shadow.pending_summaries.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end
endmodule
